>>> sv/tlpfq_pkg.sv
// Shared types, widths and codes for the three-level priority frame queue.
package tlpfq_pkg;

  localparam int LEVELS      = 3;
  localparam int OP_W        = 2;
  localparam int LVL_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_HANDLE_W = 32;
  localparam int OUT_HANDLE_W = 32;
  localparam int LEN_W       = 16;
  localparam int TIME_W      = 32;
  localparam int ELAPSED_W   = 16;
  localparam int OCC_OUT_W   = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [OP_W-1:0]         op_t;
  typedef logic [LVL_W-1:0]        level_t;
  typedef logic [STATUS_W-1:0]     status_t;
  typedef logic [IN_HANDLE_W-1:0]  in_handle_t;
  typedef logic [OUT_HANDLE_W-1:0] out_handle_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [TIME_W-1:0]       time_t;
  typedef logic [ELAPSED_W-1:0]    elapsed_t;
  typedef logic [OCC_OUT_W-1:0]    occ_out_t;
  typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_POP   = 2'd1;
  localparam op_t OP_TICK  = 2'd2;
  localparam op_t OP_FLUSH = 2'd3;

  localparam level_t LVL_LOW     = 2'd0;
  localparam level_t LVL_MEDIUM  = 2'd1;
  localparam level_t LVL_HIGH    = 2'd2;
  localparam level_t LVL_INVALID = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_TOO_LONG = 2'd2;
  localparam status_t ST_BAD_PRIO = 2'd3;

  localparam cfg_index_t CFG_TIMEOUT = 2'd0;
  localparam cfg_index_t CFG_MAX_LEN = 2'd1;

  localparam cfg_data_t TIMEOUT_RESET = 16'd500;
  localparam cfg_data_t MAX_LEN_RESET = 16'd2048;

  localparam elapsed_t ELAPSED_MAX = 16'hFFFF;

endpackage

>>> sv/three_level_priority_frame_queue.sv
// Three-level strict-priority frame descriptor queue with a starvation timer.
// The block takes one input word per clock and returns exactly one result word for each,
// shown in the cycle after acceptance; the rings' head, tail and occupancy registers
// and the descriptor RAM's single registered read port are updated at acceptance, so the
// sustained rate is one word per cycle whenever the result side keeps taking words.
// Descriptors for all three levels share one RAM of 3 x RING_DEPTH entries; a pop
// launches the RAM read at acceptance and the popped fields appear with the result.
module three_level_priority_frame_queue #(
  parameter int RING_DEPTH   = 32,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tlpfq_pkg::op_t          operation,
  input  tlpfq_pkg::level_t       priority_req,
  input  tlpfq_pkg::in_handle_t   frame_handle,
  input  tlpfq_pkg::len_t         frame_length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tlpfq_pkg::status_t      status,
  output logic                    dropped_oldest,
  output tlpfq_pkg::out_handle_t  out_handle,
  output tlpfq_pkg::len_t         out_length,
  output tlpfq_pkg::level_t       out_priority,
  output tlpfq_pkg::time_t        out_enqueue_time,
  output logic                    low_forced,
  output tlpfq_pkg::occ_out_t     high_occupancy,
  output tlpfq_pkg::occ_out_t     medium_occupancy,
  output tlpfq_pkg::occ_out_t     low_occupancy,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  tlpfq_pkg::cfg_index_t   cfg_index,
  input  tlpfq_pkg::cfg_data_t    cfg_data
);

  import tlpfq_pkg::*;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int OCC_W  = $clog2(RING_DEPTH + 1);
  localparam int DEPTH  = LEVELS * RING_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = HANDLE_WIDTH + LEN_W + TIME_W;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0]  FULL_OCC  = OCC_W'(RING_DEPTH);
  localparam logic [ADDR_W-1:0] BASE_MED  = ADDR_W'(RING_DEPTH);
  localparam logic [ADDR_W-1:0] BASE_HIGH = ADDR_W'(2 * RING_DEPTH);

  logic [IDX_W-1:0] head      [LEVELS];
  logic [IDX_W-1:0] head_next [LEVELS];
  logic [IDX_W-1:0] tail      [LEVELS];
  logic [IDX_W-1:0] tail_next [LEVELS];
  logic [OCC_W-1:0] occ       [LEVELS];
  logic [OCC_W-1:0] occ_next  [LEVELS];

  time_t     ms_clock;
  time_t     ms_clock_next;
  elapsed_t  elapsed;
  elapsed_t  elapsed_next;
  cfg_data_t timeout;
  cfg_data_t max_len;

  logic        accept;
  logic        push_ok;
  logic        forced;
  logic        pop_take;
  level_t      pop_lvl;
  status_t     status_next;
  logic        dropped_next;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic popped;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_base(input level_t lv);
    logic [ADDR_W-1:0] b;
    case (lv)
      LVL_HIGH:   b = BASE_HIGH;
      LVL_MEDIUM: b = BASE_MED;
      default:    b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [IDX_W-1:0] pick_idx(input logic [IDX_W-1:0] a0,
                                                input logic [IDX_W-1:0] a1,
                                                input logic [IDX_W-1:0] a2,
                                                input level_t lv);
    logic [IDX_W-1:0] r;
    case (lv)
      LVL_HIGH:   r = a2;
      LVL_MEDIUM: r = a1;
      default:    r = a0;
    endcase
    return r;
  endfunction

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    push_ok  = (operation == OP_PUSH) && (frame_length <= max_len) &&
               (priority_req != LVL_INVALID);
    forced   = (elapsed >= timeout) && (occ[LVL_LOW] != '0);
    pop_take = 1'b1;
    pop_lvl  = LVL_LOW;
    if (forced) begin
      pop_lvl = LVL_LOW;
    end else if (occ[LVL_HIGH] != '0) begin
      pop_lvl = LVL_HIGH;
    end else if (occ[LVL_MEDIUM] != '0) begin
      pop_lvl = LVL_MEDIUM;
    end else if (occ[LVL_LOW] != '0) begin
      pop_lvl = LVL_LOW;
    end else begin
      pop_take = 1'b0;
    end

    status_next   = ST_OK;
    dropped_next  = 1'b0;
    ms_clock_next = ms_clock;
    elapsed_next  = elapsed;
    for (int lv = 0; lv < LEVELS; lv++) begin
      head_next[lv] = head[lv];
      tail_next[lv] = tail[lv];
      occ_next[lv]  = occ[lv];
    end

    case (operation)
      OP_PUSH: begin
        if (frame_length > max_len) begin
          status_next = ST_TOO_LONG;
        end else if (priority_req == LVL_INVALID) begin
          status_next = ST_BAD_PRIO;
        end else begin
          for (int lv = 0; lv < LEVELS; lv++) begin
            if (priority_req == LVL_W'(lv)) begin
              tail_next[lv] = next_slot(tail[lv]);
              if (occ[lv] >= FULL_OCC) begin
                dropped_next  = 1'b1;
                head_next[lv] = next_slot(head[lv]);
              end else begin
                occ_next[lv] = occ[lv] + OCC_W'(1);
              end
            end
          end
        end
      end
      OP_POP: begin
        if (!pop_take) begin
          status_next  = ST_EMPTY;
          elapsed_next = '0;
        end else begin
          if (forced) begin
            elapsed_next = '0;
          end
          for (int lv = 0; lv < LEVELS; lv++) begin
            if (pop_lvl == LVL_W'(lv)) begin
              head_next[lv] = next_slot(head[lv]);
              occ_next[lv]  = occ[lv] - OCC_W'(1);
            end
          end
        end
      end
      OP_TICK: begin
        ms_clock_next = ms_clock + TIME_W'(1);
        if (elapsed != ELAPSED_MAX) begin
          elapsed_next = elapsed + ELAPSED_W'(1);
        end
      end
      default: begin
        for (int lv = 0; lv < LEVELS; lv++) begin
          head_next[lv] = tail[lv];
          occ_next[lv]  = '0;
        end
      end
    endcase
  end

  assign ram_we    = accept && push_ok;
  assign ram_waddr = ring_base(priority_req) +
                     ADDR_W'(pick_idx(tail[0], tail[1], tail[2], priority_req));
  assign ram_wdata = {HANDLE_WIDTH'(frame_handle), frame_length, ms_clock};
  assign ram_re    = accept && (operation == OP_POP) && pop_take;
  assign ram_raddr = ring_base(pop_lvl) +
                     ADDR_W'(pick_idx(head[0], head[1], head[2], pop_lvl));

  tlpfq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ms_clock  <= '0;
      elapsed   <= '0;
      timeout   <= TIMEOUT_RESET;
      max_len   <= MAX_LEN_RESET;
      for (int lv = 0; lv < LEVELS; lv++) begin
        head[lv] <= '0;
        tail[lv] <= '0;
        occ[lv]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout <= cfg_data;
          CFG_MAX_LEN: max_len <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        out_valid <= 1'b1;
        ms_clock  <= ms_clock_next;
        elapsed   <= elapsed_next;
        for (int lv = 0; lv < LEVELS; lv++) begin
          head[lv] <= head_next[lv];
          tail[lv] <= tail_next[lv];
          occ[lv]  <= occ_next[lv];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word; the popped descriptor itself arrives from the RAM read register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status           <= status_next;
      dropped_oldest   <= dropped_next;
      popped           <= ram_re;
      out_priority     <= ram_re ? pop_lvl : LVL_LOW;
      low_forced       <= ram_re && forced;
      high_occupancy   <= OCC_OUT_W'(occ_next[LVL_HIGH]);
      medium_occupancy <= OCC_OUT_W'(occ_next[LVL_MEDIUM]);
      low_occupancy    <= OCC_OUT_W'(occ_next[LVL_LOW]);
    end
  end

  assign out_handle       = popped ? OUT_HANDLE_W'(ram_rdata[LEN_W + TIME_W +: HANDLE_WIDTH])
                                   : '0;
  assign out_length       = popped ? ram_rdata[TIME_W +: LEN_W] : '0;
  assign out_enqueue_time = popped ? ram_rdata[TIME_W-1:0] : '0;

endmodule

>>> sv/tlpfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tlpfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tlpfq_checker.sv
// Port-level checker for the three-level priority frame queue, with its bind.
module tlpfq_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input tlpfq_pkg::status_t      status,
  input logic                    dropped_oldest,
  input tlpfq_pkg::out_handle_t  out_handle,
  input tlpfq_pkg::len_t         out_length,
  input tlpfq_pkg::level_t       out_priority,
  input tlpfq_pkg::time_t        out_enqueue_time,
  input logic                    low_forced
);

  import tlpfq_pkg::*;

  // A result word waiting to be taken must not change.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_handle))
    else $error("result word changed while stalled");

  // Only a successful pop carries descriptor fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      out_handle == '0 && out_length == '0 && out_enqueue_time == '0 &&
      out_priority == LVL_LOW && !low_forced)
    else $error("descriptor fields set on a failed word");

  // A starvation pop always comes from the low ring.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && low_forced |-> out_priority == LVL_LOW && status == ST_OK &&
      !dropped_oldest)
    else $error("forced pop not served from the low ring");

  // An eviction only happens on a successful push.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped_oldest |-> status == ST_OK && !low_forced)
    else $error("eviction reported on a failed word");

  // A word accepted while the result side is free is shown on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind three_level_priority_frame_queue tlpfq_checker u_tlpfq_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .dropped_oldest   (dropped_oldest),
  .out_handle       (out_handle),
  .out_length       (out_length),
  .out_priority     (out_priority),
  .out_enqueue_time (out_enqueue_time),
  .low_forced       (low_forced)
);
